FILE: src/rusc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rusc_pkg: shared types and constants
// Action codes, sweep opcodes, the sweep control struct and the FSM states
// of the rectangle union coverage engine.
// ----------------------------------------------------------------------------
package rusc_pkg;

  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int COUNT_BITS_DEF  = 16;
  // upper bound on the number of cells in the chain
  localparam int CELLS_MAX       = 64;

  localparam int FIELD_W = 13;
  localparam int AREA_W  = 48;

  localparam logic [FIELD_W-1:0] ACTIVE_RESET  = 13'd4096;
  localparam logic [FIELD_W-1:0] ROW_FIELD_MAX = 13'd8191;

  // transaction kinds on the input stream (tuser)
  localparam logic [1:0] ACT_RANGE   = 2'd0;
  localparam logic [1:0] ACT_ROW_END = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_SCAN
  } op_t;

  // broadcast to every cell while the slice address sweeps
  typedef struct packed {
    logic valid;
    op_t  op;
    logic start;
  } sweep_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SUM,
    ST_EMIT
  } state_t;

endpackage : rusc_pkg
`default_nettype wire

FILE: src/rusc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rusc_cell: one cell of the coverage chain
// Holds the counters of a contiguous slice of columns in a local memory,
// applies range updates and clears one column per cycle, counts covered
// columns on a scan and adds its count to the partial sum of its neighbor.
// ----------------------------------------------------------------------------
module rusc_cell import rusc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int SLICE      = 64,
  parameter int AW         = 6,
  parameter int WW         = 13,
  parameter int CNT_W      = 7,
  parameter int SUM_W      = 13,
  parameter logic [WW-1:0] BASE = '0
) (
  input  logic              clk,
  input  logic              rst,
  input  sweep_t            sweep,
  input  logic [AW-1:0]     addr,
  input  logic [WW-1:0]     lo,
  input  logic [WW-1:0]     hi,
  input  logic [WW-1:0]     limit,
  input  logic signed [1:0] delta,
  input  logic [SUM_W-1:0]  sum_in,
  output logic [SUM_W-1:0]  sum_out
);

  logic [COUNT_BITS-1:0] mem [SLICE];
  logic [COUNT_BITS-1:0] rd_data;
  logic [AW-1:0]         addr_q;
  sweep_t                s1;
  logic [CNT_W-1:0]      count;

  logic [WW-1:0]         col;
  logic                  in_range;
  logic                  hit;
  logic [COUNT_BITS:0]   up_sum;
  logic [COUNT_BITS-1:0] mag;
  logic [COUNT_BITS-1:0] upd;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;

  // stage 0: read the addressed counter
  always_ff @(posedge clk) begin
    rd_data <= mem[addr];
    addr_q  <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= sweep;
    end
  end

  // stage 1: modify and write back
  always_comb begin
    col      = BASE + WW'(addr_q);
    in_range = (col >= lo) && (col < hi);
    hit      = (rd_data != '0) && (col < limit);
    // magnitude of delta: +1 / 0 / -1 / -2
    if (!delta[1]) begin
      mag = COUNT_BITS'(delta[0]);
    end else begin
      mag = COUNT_BITS'({~delta[0], delta[0]});
    end
    up_sum = {1'b0, rd_data} + {1'b0, mag};
    if (!delta[1]) begin
      upd = up_sum[COUNT_BITS] ? '1 : up_sum[COUNT_BITS-1:0];
    end else begin
      upd = (rd_data > mag) ? (rd_data - mag) : '0;
    end
    wr_en   = s1.valid && ((s1.op == OP_CLEAR) || ((s1.op == OP_ADD) && in_range));
    wr_data = (s1.op == OP_CLEAR) ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
  end

  // local covered count, restarted by the first address of a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s1.valid && (s1.op == OP_SCAN)) begin
      if (s1.start) begin
        count <= CNT_W'(hit);
      end else begin
        count <= count + CNT_W'(hit);
      end
    end
  end

  // partial sum handed on to the next cell every cycle
  always_ff @(posedge clk) begin
    sum_out <= sum_in + SUM_W'(count);
  end

endmodule : rusc_cell
`default_nettype wire

FILE: src/rectangle_union_sweep_coverage_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rectangle_union_sweep_coverage_top: sweep-line union area engine
// Column coverage counters spread over a chain of cells, range add, row
// count with saturating area total, store clear.
// ----------------------------------------------------------------------------
// Usage: send each row's range transactions (tuser = 0) and then a row-end
// transaction (tuser = 1); the row end returns one result with the covered
// column count of that row and the running area total. tuser = 2 clears all
// counters and the total; tuser = 3 is taken and ignored. The counters live
// in CELLS = min(64, MAX_COLUMNS) cells, each owning a slice of
// SLICE = ceil(MAX_COLUMNS / CELLS) columns in a local memory; all cells
// step through their slice together, one column per cycle. A range add or a
// clear therefore sweeps the whole slice once. A row end scans the slice,
// then the partial count ripples through the cell chain one cell per cycle.
// After reset the store is swept to zero, during which s_tready stays low;
// configuration writes are taken at any time but must only be issued while
// the block is idle. A finished result waits in an output register, so the
// next transaction may be taken before it is read.
// ----------------------------------------------------------------------------
module rectangle_union_sweep_coverage_top import rusc_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration: active_columns
  input  logic         cfg_we,
  input  logic [12:0]  cfg_wdata,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // col_lo[12:0], col_hi[25:13], delta[27:26], zeros
  input  logic [1:0]   s_tuser,   // action[1:0]
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata    // row_covered[12:0], total_area[60:13], zeros
);

  localparam int CELLS  = (MAX_COLUMNS < CELLS_MAX) ? MAX_COLUMNS : CELLS_MAX;
  localparam int SLICE  = (MAX_COLUMNS + CELLS - 1) / CELLS;
  localparam int AW     = (SLICE > 1) ? $clog2(SLICE) : 1;
  localparam int IDX_W  = $clog2(CELLS * SLICE + 1);
  localparam int WW     = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;
  localparam int CNT_W  = $clog2(SLICE + 1);
  localparam int SUM_W  = IDX_W;
  localparam int WAIT_W = $clog2(CELLS + 3);

  // input fields
  logic [FIELD_W-1:0] col_lo;
  logic [FIELD_W-1:0] col_hi;
  logic signed [1:0]  delta;
  logic [1:0]         action;

  assign col_lo = s_tdata[12:0];
  assign col_hi = s_tdata[25:13];
  assign delta  = s_tdata[27:26];
  assign action = s_tuser;

  // registers
  state_t              state, state_next;
  logic [FIELD_W-1:0]  active_columns;
  logic [AW-1:0]       addr;
  logic [WAIT_W-1:0]   wait_cnt;
  logic [WW-1:0]       lo_q;
  logic [WW-1:0]       hi_q;
  logic [WW-1:0]       limit_q;
  logic signed [1:0]   delta_q;
  logic [AREA_W-1:0]   area;
  logic [FIELD_W-1:0]  out_row;
  logic [AREA_W-1:0]   out_total;

  // combinational
  logic                accept;
  logic                sweeping;
  logic                last_addr;
  logic                emit;
  logic [WW-1:0]       limit_w;
  logic [WW-1:0]       hi_w;
  logic [WW-1:0]       hi_eff;
  logic [WW-1:0]       row_n;
  logic [AREA_W:0]     area_sum;
  logic [AREA_W-1:0]   area_next;
  logic [FIELD_W-1:0]  row_field;
  sweep_t              sweep;
  logic [SUM_W-1:0]    sums [CELLS+1];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {3'b000, out_total, out_row};

  // swept limit and clipped range end
  always_comb begin
    limit_w = (WW'(active_columns) > WW'(MAX_COLUMNS)) ? WW'(MAX_COLUMNS)
                                                        : WW'(active_columns);
    hi_w    = WW'(col_hi);
    hi_eff  = (hi_w < limit_w) ? hi_w : limit_w;
  end

  // result from the end of the chain
  always_comb begin
    row_n     = WW'(sums[CELLS]);
    area_sum  = {1'b0, area} + (AREA_W + 1)'(row_n);
    area_next = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
    row_field = (row_n > WW'(ROW_FIELD_MAX)) ? ROW_FIELD_MAX : row_n[FIELD_W-1:0];
  end

  // FSM: next state and sweep control
  always_comb begin
    state_next = state;
    sweeping   = 1'b0;
    emit       = 1'b0;
    last_addr  = (addr == AW'(SLICE - 1));
    sweep      = '0;
    sweep.start = (addr == '0);
    case (state)
      ST_CLEAR: begin
        sweeping  = 1'b1;
        sweep.valid = 1'b1;
        sweep.op  = OP_CLEAR;
        if (last_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          case (action)
            ACT_RANGE:   state_next = ST_ADD;
            ACT_ROW_END: state_next = ST_SCAN;
            ACT_CLEAR:   state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        sweeping  = 1'b1;
        sweep.valid = 1'b1;
        sweep.op  = OP_ADD;
        if (last_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        sweeping  = 1'b1;
        sweep.valid = 1'b1;
        sweep.op  = OP_SCAN;
        if (last_addr) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        // wait for the partial count to ripple to the end of the chain
        if (wait_cnt == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // slice address, shared by all cells
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (sweeping) begin
      addr <= last_addr ? '0 : addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_cnt <= WAIT_W'(CELLS + 1);
    end else if (state != ST_SUM) begin
      wait_cnt <= WAIT_W'(CELLS + 1);
    end else begin
      wait_cnt <= wait_cnt - WAIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_columns <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_columns <= cfg_wdata;
    end
  end

  // command latched with the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_q    <= WW'(col_lo);
      hi_q    <= hi_eff;
      limit_q <= limit_w;
      delta_q <= delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area <= '0;
    end else if (accept && (action == ACT_CLEAR)) begin
      area <= '0;
    end else if (emit) begin
      area <= area_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row   <= row_field;
      out_total <= area_next;
    end
  end

  // cell chain
  assign sums[0] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    rusc_cell #(
      .COUNT_BITS (COUNT_BITS),
      .SLICE      (SLICE),
      .AW         (AW),
      .WW         (WW),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W),
      .BASE       (WW'(i * SLICE))
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .sweep   (sweep),
      .addr    (addr),
      .lo      (lo_q),
      .hi      (hi_q),
      .limit   (limit_q),
      .delta   (delta_q),
      .sum_in  (sums[i]),
      .sum_out (sums[i+1])
    );
  end

  // assertions
  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside the emit step");

  a_area_monotonic: assert property (@(posedge clk) disable iff (rst)
    (area < $past(area)) |-> $past(s_tvalid && s_tready && (s_tuser == ACT_CLEAR)))
    else $error("area total dropped without a clear");

  a_addr_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_SUM || state == ST_EMIT) |-> addr == '0)
    else $error("slice address not parked outside a sweep");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (WW'(sums[CELLS]) <= limit_q))
    else $error("row count exceeds swept columns");

endmodule : rectangle_union_sweep_coverage_top
`default_nettype wire

FILE: test/tb_rectangle_union_sweep_coverage_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectangle_union_sweep_coverage_top: union area sweep engine testbench
// Starts with a short table of directed transactions: field extremes, empty
// and clipped ranges, delta of zero and of -2, ignored action and clear.
// Then it runs random sweep phases with well-formed open/close rectangle
// sequences and some noise, under several active column settings. Each row
// end result is checked against a predictor of the engine that runs inside
// this testbench, or against a typed-in result for some directed rows.
// ----------------------------------------------------------------------------
module tb_rectangle_union_sweep_coverage_top;
  import rusc_pkg::*;

  localparam int COLS          = MAX_COLUMNS_DEF;
  localparam int COUNT_MAX     = (1 << COUNT_BITS_DEF) - 1;
  localparam logic [AREA_W-1:0] AREA_FULL = {AREA_W{1'b1}};
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 175;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_CYCLES   = 2000;   // receiver hold-off, long enough to back up the input
  localparam int SETTLE_CYCLES = 300;    // long enough for a row end or a range add to finish
  localparam int STALL_LIMIT   = 20000;  // cycles with no transaction on either side

  // action 3 is accepted and dropped by the engine
  localparam logic [1:0] ACT_IGNORED  = 2'd3;
  // two-bit signed delta codes
  localparam logic [1:0] DELTA_ZERO   = 2'b00;
  localparam logic [1:0] DELTA_OPEN   = 2'b01;
  localparam logic [1:0] DELTA_MINUS2 = 2'b10;
  localparam logic [1:0] DELTA_CLOSE  = 2'b11;

  typedef struct packed {
    logic [FIELD_W-1:0] covered;
    logic [AREA_W-1:0]  area;
  } area_report_t;

  // typed-in result for a directed row end; fixed = 0 means use the predictor
  typedef struct packed {
    logic               fixed;
    logic [FIELD_W-1:0] covered;
    logic [AREA_W-1:0]  area;
  } typed_result_t;

  typedef struct packed {
    logic [1:0]         act;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic [1:0]         dl;
    typed_result_t      res;
  } dir_row_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [12:0]  cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;   // col_lo[12:0], col_hi[25:13], delta[27:26], zeros
  logic [1:0]   s_tuser;   // action[1:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;   // row_covered[12:0], total_area[60:13], zeros

  rectangle_union_sweep_coverage_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the column counters, area total and the
  // active column register.
  // --------------------------------------------------------------------------
  logic [COUNT_BITS_DEF-1:0] cov_cnt [COLS];
  logic [AREA_W-1:0]         area_acc;
  logic [FIELD_W-1:0]        active_cols;

  area_report_t  area_reports_q [$];  // row end results still to arrive
  typed_result_t typed_q [$];         // one entry per transaction sent, in order

  int  errors;
  int  n_ranges, n_rows, n_clears, n_ignored, n_settings;
  bit  calm;       // no idling on either side
  bit  hold_req;
  bit  hold_done;

  // columns that take part in adds and counts
  function automatic int swept_cols();
    return (active_cols > COLS) ? COLS : int'(active_cols);
  endfunction

  // add delta to columns lo .. hi-1, clipped to the swept columns,
  // counters clamp at zero and at full scale
  function automatic void apply_range_add(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                                          logic [1:0] dl);
    int top;
    int step;
    top  = swept_cols();
    step = int'($signed(dl));
    if (int'(hi) < top) top = int'(hi);
    for (int c = int'(lo); c < top; c++) begin
      int nv;
      nv = int'(cov_cnt[c]) + step;
      if (nv < 0) nv = 0;
      else if (nv > COUNT_MAX) nv = COUNT_MAX;
      cov_cnt[c] = nv[COUNT_BITS_DEF-1:0];
    end
  endfunction

  function automatic int covered_columns();
    int n;
    n = 0;
    for (int c = 0; c < swept_cols(); c++)
      if (cov_cnt[c] != '0) n++;
    return n;
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t ERROR %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predicts on every accepted input transaction, checks every
  // accepted output transaction against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    typed_result_t tag;
    area_report_t  want;
    area_report_t  got;
    int            n;
    logic [AREA_W:0] sum;
    if (rst) begin
      foreach (cov_cnt[c]) cov_cnt[c] = '0;
      area_acc    = '0;
      active_cols = ACTIVE_RESET;
    end else begin
      if (cfg_we) active_cols = cfg_wdata;
      if (s_tvalid && s_tready) begin
        tag = typed_q.pop_front();
        case (s_tuser)
          ACT_RANGE: begin
            apply_range_add(s_tdata[12:0], s_tdata[25:13], s_tdata[27:26]);
            n_ranges++;
          end
          ACT_ROW_END: begin
            n   = covered_columns();
            sum = {1'b0, area_acc} + (AREA_W + 1)'(n);
            // total saturates instead of wrapping
            area_acc     = sum[AREA_W] ? AREA_FULL : sum[AREA_W-1:0];
            want.covered = (n > int'(ROW_FIELD_MAX)) ? ROW_FIELD_MAX : n[FIELD_W-1:0];
            want.area    = area_acc;
            if (tag.fixed) begin
              want.covered = tag.covered;
              want.area    = tag.area;
            end
            area_reports_q.insert(area_reports_q.size(), want);
            n_rows++;
          end
          ACT_CLEAR: begin
            foreach (cov_cnt[c]) cov_cnt[c] = '0;
            area_acc = '0;
            n_clears++;
          end
          default: n_ignored++;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.covered = m_tdata[12:0];
        got.area    = m_tdata[60:13];
        if (area_reports_q.size() == 0) begin
          note_error($sformatf("result with nothing expected: covered %0d area %0d",
                               got.covered, got.area));
        end else begin
          want = area_reports_q.pop_front();
          if (got.covered !== want.covered || got.area !== want.area)
            note_error($sformatf("row result: expected covered %0d area %0d, got %0d / %0d",
                                 want.covered, want.area, got.covered, got.area));
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) break;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb_rectangle_union_sweep_coverage_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random ready gaps, plus one long hold-off on request so the
  // output register fills and the engine stalls its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offers one transaction and returns in the time step it is accepted.
  task automatic push_item(logic [1:0] act, logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                           logic [1:0] dl, typed_result_t res);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    typed_q.insert(typed_q.size(), res);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0000, dl, hi, lo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Waits for every row result, then for any range add or clear in flight.
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (area_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(logic [FIELD_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  // Mostly rectangles opening and closing over the swept width, row ends in
  // between; one in ten transactions is noise with raw field values.
  task automatic run_sweep_phase(int span, bit with_hold);
    logic [FIELD_W-1:0] open_lo [$];
    logic [FIELD_W-1:0] open_hi [$];
    logic [FIELD_W-1:0] lo, hi;
    logic [1:0]         act;
    int                 sent, k, pick;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if (with_hold && sent == 30) hold_req = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) act = ACT_RANGE;
        else if (pick < 7) act = ACT_ROW_END;
        else if (pick < 9) act = ACT_IGNORED;
        else act = ACT_CLEAR;
        push_item(act, FIELD_W'($urandom_range(0, 8191)), FIELD_W'($urandom_range(0, 8191)),
                  2'($urandom_range(0, 3)), '0);
        if (act == ACT_CLEAR) begin
          open_lo.delete();
          open_hi.delete();
        end
        if (act != ACT_IGNORED) sent++;
      end else if (open_lo.size() == 0 ||
                   (open_lo.size() < 8 && $urandom_range(0, 1) == 1)) begin
        lo = FIELD_W'($urandom_range(0, span));
        // now and then a range that runs past the swept columns
        if ($urandom_range(0, 7) == 0) hi = FIELD_W'($urandom_range(int'(lo), 8191));
        else hi = FIELD_W'($urandom_range(int'(lo), span));
        push_item(ACT_RANGE, lo, hi, DELTA_OPEN, '0);
        open_lo.insert(open_lo.size(), lo);
        open_hi.insert(open_hi.size(), hi);
        sent++;
      end else begin
        k = $urandom_range(0, open_lo.size() - 1);
        push_item(ACT_RANGE, open_lo[k], open_hi[k], DELTA_CLOSE, '0);
        open_lo.delete(k);
        open_hi.delete(k);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) begin
        // range fields are don't-care on a row end; keep them random
        push_item(ACT_ROW_END, FIELD_W'($urandom_range(0, 8191)),
                  FIELD_W'($urandom_range(0, 8191)), 2'($urandom_range(0, 3)), '0);
        sent++;
      end
    end
  endtask

  // Directed rows, run at the reset width of 4096 columns. Typed results
  // only where they are plain: fresh state, full width, after a clear.
  dir_row_t dir_rows [23] = '{
    '{ACT_ROW_END, 13'd0,    13'd0,    DELTA_ZERO,   '{1'b1, 13'd0,    48'd0}},
    '{ACT_RANGE,   13'd0,    13'd4096, DELTA_OPEN,   '0},
    '{ACT_ROW_END, 13'd8191, 13'd8191, DELTA_MINUS2, '{1'b1, 13'd4096, 48'd4096}},
    // clipped at the swept width: only the last column closes
    '{ACT_RANGE,   13'd4095, 13'd8191, DELTA_CLOSE,  '0},
    '{ACT_ROW_END, 13'd0,    13'd0,    DELTA_ZERO,   '{1'b1, 13'd4095, 48'd8191}},
    '{ACT_RANGE,   13'd100,  13'd50,   DELTA_OPEN,   '0},   // reversed, empty
    '{ACT_RANGE,   13'd0,    13'd0,    DELTA_OPEN,   '0},   // empty at zero
    '{ACT_RANGE,   13'd10,   13'd20,   DELTA_MINUS2, '0},   // -2 clamps at zero
    '{ACT_RANGE,   13'd0,    13'd4096, DELTA_ZERO,   '0},
    '{ACT_IGNORED, 13'd8191, 13'd8191, DELTA_MINUS2, '0},
    '{ACT_RANGE,   13'd8191, 13'd8191, DELTA_OPEN,   '0},
    '{ACT_RANGE,   13'd5000, 13'd6000, DELTA_OPEN,   '0},   // wholly past the width
    '{ACT_ROW_END, 13'd1234, 13'd42,   DELTA_OPEN,   '0},
    '{ACT_RANGE,   13'd0,    13'd1,    DELTA_OPEN,   '0},
    '{ACT_RANGE,   13'd0,    13'd1,    DELTA_CLOSE,  '0},
    '{ACT_ROW_END, 13'd0,    13'd0,    DELTA_ZERO,   '0},
    '{ACT_CLEAR,   13'd8191, 13'd0,    DELTA_CLOSE,  '0},
    '{ACT_ROW_END, 13'd0,    13'd0,    DELTA_ZERO,   '{1'b1, 13'd0,    48'd0}},
    '{ACT_RANGE,   13'd0,    13'd1,    DELTA_OPEN,   '0},
    '{ACT_ROW_END, 13'd0,    13'd0,    DELTA_ZERO,   '{1'b1, 13'd1,    48'd1}},
    '{ACT_RANGE,   13'd2730, 13'd5461, DELTA_OPEN,   '0},   // alternating bit patterns
    '{ACT_ROW_END, 13'd5461, 13'd2730, DELTA_CLOSE,  '0},
    '{ACT_CLEAR,   13'd0,    13'd0,    DELTA_ZERO,   '0}
  };

  initial begin : stimulus
    logic [FIELD_W-1:0] phase_cols [PHASES];
    int                 span;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    errors    = 0;
    n_ranges  = 0;
    n_rows    = 0;
    n_clears  = 0;
    n_ignored = 0;
    n_settings = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // the engine clears its store after reset; push_item waits for tready
    foreach (dir_rows[i])
      push_item(dir_rows[i].act, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].dl,
                dir_rows[i].res);
    drain_and_settle();

    // single column, none, above the store size, random, one short, random, full
    phase_cols = '{13'd1, 13'd0, 13'd8191, 13'($urandom_range(2, 4094)), 13'd4095,
                   13'($urandom_range(2, 4094)), 13'd4096};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_active(phase_cols[ph]);
      span = (phase_cols[ph] > COLS) ? COLS : int'(phase_cols[ph]);
      calm = (ph == PHASES - 1);
      run_sweep_phase(span, ph == HOLD_PHASE);
      drain_and_settle();
    end

    if (area_reports_q.size() != 0)
      note_error($sformatf("%0d row results never arrived", area_reports_q.size()));

    $display("covered %0d range adds, %0d row ends, %0d clears, %0d ignored transactions",
             n_ranges, n_rows, n_clears, n_ignored);
    $display("over %0d column width settings incl. 0, 1 and 8191, one %0d-cycle result hold-off",
             n_settings, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb_rectangle_union_sweep_coverage_top: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_rectangle_union_sweep_coverage_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rusc_pkg.sv
src/rusc_cell.sv
src/rectangle_union_sweep_coverage_top.sv
test/tb_rectangle_union_sweep_coverage_top.sv
